// File: hw/rtl/mcks_pkg.sv
// Shared constants, types and the Magma round function for the keystream generator.
// No dependencies; used by mcks_ctrl, mcks_dp and the top level.
package mcks_pkg;

  localparam int unsigned LANES      = 8;
  localparam int unsigned IDX_W      = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned POS_W      = $clog2(LANES + 1);
  localparam int unsigned ROUNDS     = 32;
  localparam int unsigned RND_W      = $clog2(ROUNDS);
  localparam int unsigned FWD_ROUNDS = 24;
  localparam int unsigned KEYS       = 8;
  localparam int unsigned KEY_W      = $clog2(KEYS);
  localparam int unsigned BATCH_W    = 61;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY45 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY67 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN = 3'd4;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // Controller to datapath commands
  typedef struct packed {
    logic             clear;
    logic             load;
    logic             round;
    logic             out_load;
    logic [KEY_W-1:0] key_idx;
    logic [IDX_W-1:0] pos;
  } cmd_t;

  // Round function: add key, substitute each nibble, rotate left by 11
  function automatic logic [HALF_W-1:0] g_func(input logic [HALF_W-1:0] k,
                                               input logic [HALF_W-1:0] a);
    logic [HALF_W-1:0] x;
    logic [HALF_W-1:0] y;
    x = a + k;
    for (int n = 0; n < 8; n++) begin
      y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
    end
    return {y[HALF_W-12:0], y[HALF_W-1:HALF_W-11]};
  endfunction

endpackage

// File: hw/rtl/mcks_ctrl.sv
// Controller for the keystream generator: handshakes, buffer position, round count.
// Depends on mcks_pkg; drives mcks_dp through mcks_pkg::cmd_t.
module mcks_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                restart,
  output logic                out_tvalid,
  input  logic                out_tready,
  output mcks_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_DELIVER} state_t;

  state_t                          state_r, state_nxt;
  logic [mcks_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [mcks_pkg::RND_W-1:0]      rnd_r, rnd_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.pos       = pos_r[mcks_pkg::IDX_W-1:0];
    // forward key order for the first rounds, then reversed
    cmd.key_idx   = (32'(rnd_r) < mcks_pkg::FWD_ROUNDS) ? rnd_r[mcks_pkg::KEY_W-1:0]
                                                        : ~rnd_r[mcks_pkg::KEY_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (restart) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else if (32'(pos_r) >= mcks_pkg::LANES) begin
            state_nxt = S_LOAD;
          end else if (out_free) begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
            pos_nxt       = pos_r + 1'b1;
          end else begin
            state_nxt = S_DELIVER;
          end
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 1'b1;
        if (32'(rnd_r) == mcks_pkg::ROUNDS - 1) begin
          pos_nxt   = '0;
          state_nxt = S_DELIVER;
        end
      end
      S_DELIVER: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= mcks_pkg::POS_W'(mcks_pkg::LANES);
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output beat overwritten before it was taken");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (32'(pos_r) < mcks_pkg::LANES))
    else $error("word read from an empty buffer");

  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && 32'(rnd_r) == mcks_pkg::ROUNDS - 1) |=>
      (state_r == S_DELIVER && pos_r == '0))
    else $error("refill did not end in delivery of word zero");

  a_restart_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && restart) |=> (state_r == S_LOAD))
    else $error("restart did not start a refill");

endmodule

// File: hw/rtl/mcks_dp.sv
// Datapath for the keystream generator: key registers, batch counter, lane round
// units (which also hold the buffered words) and the output register. Uses mcks_pkg.
module mcks_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [mcks_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mcks_pkg::WORD_W-1:0]            cfg_wdata,
  input  mcks_pkg::cmd_t                         cmd,
  output logic [mcks_pkg::WORD_W-1:0]            out_word
);

  logic [mcks_pkg::HALF_W-1:0]  key_r [mcks_pkg::KEYS];
  logic                         chain_r;
  logic [mcks_pkg::BATCH_W-1:0] batch_r;
  logic [mcks_pkg::HALF_W-1:0]  hi_r [mcks_pkg::LANES];
  logic [mcks_pkg::HALF_W-1:0]  lo_r [mcks_pkg::LANES];
  logic [mcks_pkg::WORD_W-1:0]  out_r;
  logic [mcks_pkg::HALF_W-1:0]  rkey;

  assign rkey     = key_r[cmd.key_idx];
  assign out_word = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mcks_pkg::KEYS; k++) begin
        key_r[k] <= '0;
      end
      chain_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcks_pkg::CFG_KEY01: begin
          key_r[0] <= cfg_wdata[63:32];
          key_r[1] <= cfg_wdata[31:0];
        end
        mcks_pkg::CFG_KEY23: begin
          key_r[2] <= cfg_wdata[63:32];
          key_r[3] <= cfg_wdata[31:0];
        end
        mcks_pkg::CFG_KEY45: begin
          key_r[4] <= cfg_wdata[63:32];
          key_r[5] <= cfg_wdata[31:0];
        end
        mcks_pkg::CFG_KEY67: begin
          key_r[6] <= cfg_wdata[63:32];
          key_r[7] <= cfg_wdata[31:0];
        end
        mcks_pkg::CFG_CHAIN: chain_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Lanes hold the final round halves; the buffered word is {lo, hi}.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      batch_r <= '0;
      for (int i = 0; i < mcks_pkg::LANES; i++) begin
        hi_r[i] <= '0;
        lo_r[i] <= '0;
      end
    end else if (cmd.load) begin
      batch_r <= batch_r + 1'b1;
      for (int i = 0; i < mcks_pkg::LANES; i++) begin
        logic [mcks_pkg::WORD_W-1:0] ctr;
        ctr = 64'(64'(batch_r) * 64'(mcks_pkg::LANES)) + 64'(i);
        // chain with the previous word, halves swapped back into block order
        if (chain_r) begin
          ctr = ctr ^ {hi_r[i], lo_r[i]};
        end
        hi_r[i] <= ctr[63:32];
        lo_r[i] <= ctr[31:0];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < mcks_pkg::LANES; i++) begin
        hi_r[i] <= lo_r[i];
        lo_r[i] <= hi_r[i] ^ mcks_pkg::g_func(rkey, lo_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= {lo_r[cmd.pos], hi_r[cmd.pos]};
    end
  end

endmodule

// File: hw/rtl/magma_counter_keystream_generator_top.sv
// Top level of the Magma counter-mode keystream generator.
// Depends on mcks_pkg, mcks_ctrl and mcks_dp.
//
//  channel  direction  beat contents
//  in_      slave      tdata[0] restart, tdata[7:1] zero
//  out_     master     tdata[63:0] random_word
//  cfg_     write      index 0..3 key word pairs, 4 chaining mode
//
// A word from a filled buffer goes to the output register on accept if that is free,
// else from S_DELIVER once it frees. Every eighth word (and any restart) refills the
// buffer: a load step, 32 rounds in the eight lane round units and a delivery step;
// no new word is accepted until the refilled word has been delivered.
// Reset is synchronous, active low; the buffer starts empty and all zero.
// A waiting output beat does not block the next accept; a new word waits for it.
module magma_counter_keystream_generator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] restart, [7:1] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mcks_pkg::WORD_W-1:0]      out_tdata,  // [63:0] random_word
  input  logic                             cfg_we,
  input  logic [mcks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcks_pkg::WORD_W-1:0]      cfg_wdata
);

  mcks_pkg::cmd_t cmd;

  mcks_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .restart    (in_tdata[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mcks_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .out_word  (out_tdata)
  );

endmodule

// File: tb/magma_counter_keystream_generator_top_test.sv
// Self-checking testbench for the Magma counter-mode keystream generator.
// Depends on mcks_pkg and magma_counter_keystream_generator_top; the cipher is
// predicted locally and every output beat is checked in order.
module magma_counter_keystream_generator_top_test;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS     = 125;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ERROR_PRINTS    = 100;

  // Indexes past the last register; writes there must be ignored
  localparam logic [mcks_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [mcks_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [3:0] SUBST [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  logic                                clk        = 1'b0;
  logic                                rst_n      = 1'b0;
  logic                                in_tvalid  = 1'b0;
  logic                                in_tready;
  logic [7:0]                          in_tdata   = '0;   // [0] restart, [7:1] zero
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [mcks_pkg::WORD_W-1:0]         out_tdata;         // [63:0] random_word
  logic                                cfg_we     = 1'b0;
  logic [mcks_pkg::CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [mcks_pkg::WORD_W-1:0]         cfg_wdata  = '0;

  magma_counter_keystream_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted generator state
  logic [31:0] key_word [8];
  logic        chain_on;
  logic [60:0] batch_no;
  logic [63:0] word_buf [8];
  int unsigned word_pos;

  bit          restart_requests [$];
  logic [63:0] expected_words [$];
  logic [63:0] want_word;
  logic        beat_taken = 1'b0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_left  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] round_mix(input logic [31:0] k, input logic [31:0] a);
    logic [31:0] x;
    logic [31:0] y;
    x = a + k;
    for (int n = 0; n < 8; n++) begin
      y[4*n +: 4] = SUBST[n][x[4*n +: 4]];
    end
    return {y[20:0], y[31:21]};
  endfunction

  function automatic logic [63:0] magma_encrypt(input logic [63:0] blk);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] t;
    int unsigned ki;
    hi = blk[63:32];
    lo = blk[31:0];
    for (int r = 0; r < 32; r++) begin
      // three forward key passes, then one reversed
      ki = (r < 24) ? (r % 8) : (7 - (r % 8));
      t  = hi ^ round_mix(key_word[ki], lo);
      hi = lo;
      lo = t;
    end
    return {lo, hi};
  endfunction

  function automatic logic [63:0] next_keystream_word(input logic restart);
    logic [63:0] ctr;
    if (restart) begin
      batch_no = '0;
      for (int i = 0; i < 8; i++) word_buf[i] = '0;
      word_pos = 8;
    end
    if (word_pos >= 8) begin
      for (int i = 0; i < 8; i++) begin
        ctr = {batch_no, 3'(i)};
        // stored word is a0:a1, the counter block a1:a0
        if (chain_on) ctr ^= {word_buf[i][31:0], word_buf[i][63:32]};
        word_buf[i] = magma_encrypt(ctr);
      end
      batch_no++;
      word_pos = 0;
    end
    next_keystream_word = word_buf[word_pos];
    word_pos++;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < ERROR_PRINTS) $display("error: %s", msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [mcks_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      mcks_pkg::CFG_KEY01: begin key_word[0] = value[63:32]; key_word[1] = value[31:0]; end
      mcks_pkg::CFG_KEY23: begin key_word[2] = value[63:32]; key_word[3] = value[31:0]; end
      mcks_pkg::CFG_KEY45: begin key_word[4] = value[63:32]; key_word[5] = value[31:0]; end
      mcks_pkg::CFG_KEY67: begin key_word[6] = value[63:32]; key_word[7] = value[31:0]; end
      mcks_pkg::CFG_CHAIN: chain_on = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_keys(input logic [63:0] k01, input logic [63:0] k23,
                            input logic [63:0] k45, input logic [63:0] k67);
    write_reg(mcks_pkg::CFG_KEY01, k01);
    write_reg(mcks_pkg::CFG_KEY23, k23);
    write_reg(mcks_pkg::CFG_KEY45, k45);
    write_reg(mcks_pkg::CFG_KEY67, k67);
  endtask

  // Wait until every queued request is answered, then let the block go quiet
  task automatic settle();
    while (restart_requests.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned mode,
                           input int unsigned hold);
    @(posedge clk);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 65; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 65; end
      default: begin idle_pct = 28; stall_pct = 28; end
    endcase
    hold_left = hold;
    // mostly long runs through many batches, with the odd restart
    repeat (count) restart_requests.push_back($urandom_range(31) == 0);
    settle();
  endtask

  // Sender: hold a beat until taken, then offer the next or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || beat_taken) begin
      if (restart_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, restart_requests[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_words.push_back(next_keystream_word(in_tdata[0]));
        void'(restart_requests.pop_front());
        beat_taken <= 1'b1;
      end else begin
        beat_taken <= 1'b0;
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          flag_error($sformatf("unexpected word %h", out_tdata));
        end else begin
          want_word = expected_words.pop_front();
          if (out_tdata !== want_word)
            flag_error($sformatf("random_word %h, expected %h", out_tdata, want_word));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) begin
      key_word[i] = '0;
      word_buf[i] = '0;
    end
    chain_on = 1'b0;
    batch_no = '0;
    word_pos = 8;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: zero key, counter mode, across two refills
    @(posedge clk);
    repeat (9) restart_requests.push_back(1'b0);
    settle();

    // Stray indexes ignored; all-ones key; chaining from a full-width value
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    write_keys('1, '1, '1, '1);
    write_reg(mcks_pkg::CFG_CHAIN, '1);
    @(posedge clk);
    restart_requests.push_back(1'b1);
    repeat (15) restart_requests.push_back(1'b0);
    restart_requests.push_back(1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_keys('0, '0, '0, '0);
          // only bit 0 counts: this turns chaining off
          write_reg(mcks_pkg::CFG_CHAIN, 64'hFFFF_FFFF_FFFF_FFFE);
        end
        1: begin
          write_keys('1, '1, '1, '1);
          write_reg(mcks_pkg::CFG_CHAIN, 64'd1);
        end
        default: begin
          write_keys({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
          write_reg(mcks_pkg::CFG_CHAIN, {$urandom, $urandom});
        end
      endcase
      run_phase(PHASE_ITEMS, p % 4, (p == 0) ? HOLD_OFF_CYCLES : 0);
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mcks_pkg.sv
hw/rtl/mcks_ctrl.sv
hw/rtl/mcks_dp.sv
hw/rtl/magma_counter_keystream_generator_top.sv
tb/magma_counter_keystream_generator_top_test.sv
